// ===== hw/rtl/ksst_pkg.sv =====
package ksst_pkg;

  localparam int unsigned KEY_SLOTS    = 16;
  localparam int unsigned SENSOR_SLOTS = 16;
  localparam int unsigned KEY_CHARS    = 8;
  localparam int unsigned ID_CHARS     = 8;

  localparam int unsigned KEY_AW  = $clog2(KEY_SLOTS);
  localparam int unsigned SEN_AW  = $clog2(SENSOR_SLOTS);
  localparam int unsigned KCNT_W  = $clog2(KEY_SLOTS + 1);
  localparam int unsigned SCNT_W  = $clog2(SENSOR_SLOTS + 1);
  localparam int unsigned LIMIT_W = 5;

  localparam int unsigned IN_W  = 160;
  localparam int unsigned OUT_W = 184;

  // Only the leading characters (top bytes) of a name take part.
  localparam logic [63:0] KEY_MASK =
    (KEY_CHARS >= 8) ? {64{1'b1}} : ~({64{1'b1}} >> (KEY_CHARS * 8));
  localparam logic [63:0] ID_MASK =
    (ID_CHARS >= 8) ? {64{1'b1}} : ~({64{1'b1}} >> (ID_CHARS * 8));

  // Configuration register indexes.
  localparam logic CFG_KEY_LIMIT    = 1'b0;
  localparam logic CFG_SENSOR_LIMIT = 1'b1;

  // Key status codes.
  localparam logic [1:0] KST_UPDATED = 2'd0;
  localparam logic [1:0] KST_ADDED   = 2'd1;
  localparam logic [1:0] KST_DROPPED = 2'd2;
  localparam logic [1:0] KST_CLEARED = 2'd3;

  // Sensor status codes.
  localparam logic [1:0] SST_KNOWN   = 2'd0;
  localparam logic [1:0] SST_ADDED   = 2'd1;
  localparam logic [1:0] SST_FULL    = 2'd2;
  localparam logic [1:0] SST_CLEARED = 2'd3;

  // One row of the key table.
  typedef struct packed {
    logic [63:0]        word;
    logic signed [31:0] last;
    logic signed [31:0] min;
    logic signed [31:0] max;
    logic signed [47:0] mean;
    logic [31:0]        cnt;
  } key_entry_t;

  localparam int unsigned KENT_W = $bits(key_entry_t);

endpackage

// ===== hw/rtl/ksst_ram.sv =====
module ksst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/keyed_sensor_statistics_table_core.sv =====
// Keyed sensor statistics table. Each item on the slave stream is a reading
// (tuser low) or a clear (tuser high); every item yields exactly one result
// item on the master stream. Keys and sensor IDs live in two single-port-read
// memories that are searched one entry per cycle, both in parallel. A hit on
// a known key then runs a bit-serial multiply of the stored mean by the
// sample count and a restoring division by count+1 (a load and then one
// quotient bit per cycle); an append or a dropped reading skips both, and a
// clear skips the search too. One item is worked on at a time; the result
// register lets the next item in while the previous result waits to be taken.
module keyed_sensor_statistics_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ksst_pkg::LIMIT_W-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // sensor_name[63:0], key_name[127:64], reading_value[159:128]
  input  logic [ksst_pkg::IN_W-1:0]    s_axis_tdata,
  // mode (1 = clear both tables)
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // key_status[1:0], sensor_status[3:2], last_value[35:4], min_value[67:36],
  // max_value[99:68], mean_value[147:100], sample_count[179:148], zero pad
  output logic [ksst_pkg::OUT_W-1:0]   m_axis_tdata
);
  import ksst_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [LIMIT_W-1:0] key_limit_q, sensor_limit_q;
  logic [KCNT_W-1:0]  keys_used_q, keys_used_d;
  logic [SCNT_W-1:0]  sens_used_q, sens_used_d;

  logic [63:0]        key_q, key_d, sen_q, sen_d;
  logic signed [31:0] val_q, val_d;
  logic               clr_q, clr_d;

  // Search bookkeeping for both tables.
  logic [KCNT_W-1:0]  krd_q, krd_d;
  logic [KEY_AW-1:0]  kcmp_q, kcmp_d, kidx_q, kidx_d;
  logic               kpend_q, kpend_d, kdone_q, kdone_d, khit_q, khit_d;
  logic [SCNT_W-1:0]  srd_q, srd_d;
  logic               spend_q, spend_d, sdone_q, sdone_d, shit_q, shit_d;

  // Entry captured on a key hit.
  logic signed [31:0] e_min_q, e_min_d, e_max_q, e_max_d;
  logic [31:0]        e_cnt_q, e_cnt_d;
  logic               mneg_q, mneg_d;
  logic [47:0]        mmag_q, mmag_d;

  // Multiply and divide datapath.
  logic signed [80:0] acc_q, acc_d;
  logic [80:0]        mcand_q, mcand_d;
  logic [31:0]        csh_q, csh_d;
  logic [32:0]        dvs_q, dvs_d;
  logic [32:0]        rem_q, rem_d;
  logic [47:0]        dvd_q, dvd_d;
  logic               qneg_q, qneg_d;
  logic [5:0]         step_q, step_d;

  logic [1:0]         kst_q, kst_d, sst_q, sst_d;

  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_q, out_d;

  // Memory ports.
  key_entry_t         krd_data, kwr_data;
  logic [KENT_W-1:0]  krd_raw;
  logic               kwe, swe;
  logic [KEY_AW-1:0]  kwaddr;
  logic [SEN_AW-1:0]  swaddr;
  logic [63:0]        srd_data;

  ksst_ram #(.Width(KENT_W), .Depth(KEY_SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (kwaddr),
    .wdata_i (kwr_data),
    .raddr_i (krd_q[KEY_AW-1:0]),
    .rdata_o (krd_raw)
  );

  ksst_ram #(.Width(64), .Depth(SENSOR_SLOTS)) u_sen_ram (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i (swaddr),
    .wdata_i (sen_q),
    .raddr_i (srd_q[SEN_AW-1:0]),
    .rdata_o (srd_data)
  );

  assign krd_data = key_entry_t'(krd_raw);

  // Effective limits, capped at the slot counts.
  logic [31:0] klim, slim;
  assign klim = (32'(key_limit_q) < 32'(KEY_SLOTS)) ? 32'(key_limit_q) : 32'(KEY_SLOTS);
  assign slim = (32'(sensor_limit_q) < 32'(SENSOR_SLOTS)) ?
                32'(sensor_limit_q) : 32'(SENSOR_SLOTS);

  logic        kmatch, smatch;
  logic [33:0] rem_sh, diff;
  logic [80:0] acc_abs;
  logic [47:0] mean_new;
  logic signed [31:0] new_min, new_max;
  logic [31:0] new_cnt;

  assign kmatch  = kpend_q && (krd_data.word == key_q);
  assign smatch  = spend_q && (srd_data == sen_q);
  assign rem_sh  = {rem_q, dvd_q[47]};
  assign diff    = rem_sh - {1'b0, dvs_q};
  assign acc_abs = acc_q[80] ? 81'(-acc_q) : 81'(acc_q);
  assign mean_new = qneg_q ? 48'(-dvd_q) : dvd_q;
  assign new_min = (val_q < e_min_q) ? val_q : e_min_q;
  assign new_max = (val_q > e_max_q) ? val_q : e_max_q;
  assign new_cnt = (e_cnt_q == 32'hFFFF_FFFF) ? e_cnt_q : e_cnt_q + 32'd1;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_limit_q    <= LIMIT_W'(16);
      sensor_limit_q <= LIMIT_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LIMIT:    key_limit_q    <= cfg_data_i;
        CFG_SENSOR_LIMIT: sensor_limit_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Sequencer: search, then multiply and divide on a key hit, then write back and present.
  always_comb begin
    state_d     = state_q;
    keys_used_d = keys_used_q;
    sens_used_d = sens_used_q;
    key_d = key_q; sen_d = sen_q; val_d = val_q; clr_d = clr_q;
    krd_d = krd_q; kcmp_d = kcmp_q; kidx_d = kidx_q;
    kpend_d = kpend_q; kdone_d = kdone_q; khit_d = khit_q;
    srd_d = srd_q; spend_d = spend_q; sdone_d = sdone_q; shit_d = shit_q;
    e_min_d = e_min_q; e_max_d = e_max_q; e_cnt_d = e_cnt_q;
    mneg_d = mneg_q; mmag_d = mmag_q;
    acc_d = acc_q; mcand_d = mcand_q; csh_d = csh_q; dvs_d = dvs_q;
    rem_d = rem_q; dvd_d = dvd_q; qneg_d = qneg_q; step_d = step_q;
    kst_d = kst_q; sst_d = sst_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    kwe = 1'b0; swe = 1'b0;
    kwaddr = kidx_q;
    swaddr = sens_used_q[SEN_AW-1:0];
    kwr_data = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sen_d   = s_axis_tdata[63:0] & ID_MASK;
          key_d   = s_axis_tdata[127:64] & KEY_MASK;
          val_d   = s_axis_tdata[159:128];
          clr_d   = s_axis_tuser;
          krd_d   = '0; kpend_d = 1'b0; kdone_d = 1'b0; khit_d = 1'b0;
          srd_d   = '0; spend_d = 1'b0; sdone_d = 1'b0; shit_d = 1'b0;
          state_d = s_axis_tuser ? ST_FINISH : ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // Key table: one read issued and one compare done per cycle.
        if (!kdone_q) begin
          if (kmatch) begin
            khit_d  = 1'b1;
            kdone_d = 1'b1;
            kidx_d  = kcmp_q;
            e_min_d = krd_data.min;
            e_max_d = krd_data.max;
            e_cnt_d = krd_data.cnt;
            mneg_d  = krd_data.mean[47];
            mmag_d  = krd_data.mean[47] ? 48'(-krd_data.mean) : 48'(krd_data.mean);
          end else if (krd_q < keys_used_q) begin
            kpend_d = 1'b1;
            kcmp_d  = krd_q[KEY_AW-1:0];
            krd_d   = krd_q + KCNT_W'(1);
          end else begin
            kpend_d = 1'b0;
            kdone_d = 1'b1;
          end
        end
        // Sensor table, same scheme.
        if (!sdone_q) begin
          if (smatch) begin
            shit_d  = 1'b1;
            sdone_d = 1'b1;
          end else if (srd_q < sens_used_q) begin
            spend_d = 1'b1;
            srd_d   = srd_q + SCNT_W'(1);
          end else begin
            spend_d = 1'b0;
            sdone_d = 1'b1;
          end
        end
        if (kdone_q && sdone_q) begin
          sst_d = shit_q ? SST_KNOWN :
                  (32'(sens_used_q) < slim) ? SST_ADDED : SST_FULL;
          if (khit_q) begin
            kst_d   = KST_UPDATED;
            acc_d   = {{33{val_q[31]}}, val_q, 16'd0};
            mcand_d = {33'd0, mmag_q};
            csh_d   = e_cnt_q;
            dvs_d   = {1'b0, e_cnt_q} + 33'd1;
            step_d  = '0;
            state_d = ST_MUL;
          end else begin
            kst_d   = (32'(keys_used_q) < klim) ? KST_ADDED : KST_DROPPED;
            kidx_d  = keys_used_q[KEY_AW-1:0];
            state_d = ST_FINISH;
          end
        end
      end

      // Signed sum v*2^16 +/- |mean|*count, one multiplier bit per cycle.
      ST_MUL: begin
        if (csh_q[0]) begin
          acc_d = mneg_q ? acc_q - $signed(mcand_q) : acc_q + $signed(mcand_q);
        end
        mcand_d = {mcand_q[79:0], 1'b0};
        csh_d   = {1'b0, csh_q[31:1]};
        step_d  = step_q + 6'd1;
        if (step_q == 6'd31) begin
          step_d  = '0;
          state_d = ST_DIV;
        end
      end

      // Restoring division; the top bits of the magnitude are already below
      // the divisor, so 48 quotient bits remain.
      ST_DIV: begin
        step_d = step_q + 6'd1;
        if (step_q == 6'd0) begin
          qneg_d = acc_q[80];
          rem_d  = {1'b0, acc_abs[79:48]};
          dvd_d  = acc_abs[47:0];
        end else begin
          if (!diff[33]) begin
            rem_d = diff[32:0];
            dvd_d = {dvd_q[46:0], 1'b1};
          end else begin
            rem_d = rem_sh[32:0];
            dvd_d = {dvd_q[46:0], 1'b0};
          end
          if (step_q == 6'd48) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = ST_IDLE;
          if (clr_q) begin
            keys_used_d = '0;
            sens_used_d = '0;
            out_d[1:0]  = KST_CLEARED;
            out_d[3:2]  = SST_CLEARED;
          end else begin
            kwr_data.word = key_q;
            kwr_data.last = val_q;
            case (kst_q)
              KST_UPDATED: begin
                kwr_data.min  = new_min;
                kwr_data.max  = new_max;
                kwr_data.mean = mean_new;
                kwr_data.cnt  = new_cnt;
                kwe = 1'b1;
              end
              KST_ADDED: begin
                kwr_data.min  = val_q;
                kwr_data.max  = val_q;
                kwr_data.mean = {val_q, 16'd0};
                kwr_data.cnt  = 32'd1;
                kwe = 1'b1;
                keys_used_d = keys_used_q + KCNT_W'(1);
              end
              default: ;
            endcase
            if (sst_q == SST_ADDED) begin
              swe = 1'b1;
              sens_used_d = sens_used_q + SCNT_W'(1);
            end
            out_d[1:0] = kst_q;
            out_d[3:2] = sst_q;
            if (kwe) begin
              out_d[35:4]    = kwr_data.last;
              out_d[67:36]   = kwr_data.min;
              out_d[99:68]   = kwr_data.max;
              out_d[147:100] = kwr_data.mean;
              out_d[179:148] = kwr_data.cnt;
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keys_used_q <= '0;
      sens_used_q <= '0;
      out_valid_q <= 1'b0;
      kpend_q <= 1'b0; kdone_q <= 1'b0; khit_q <= 1'b0;
      spend_q <= 1'b0; sdone_q <= 1'b0; shit_q <= 1'b0;
      krd_q   <= '0;   srd_q   <= '0;   step_q <= '0;
    end else begin
      state_q     <= state_d;
      keys_used_q <= keys_used_d;
      sens_used_q <= sens_used_d;
      out_valid_q <= out_valid_d;
      kpend_q <= kpend_d; kdone_q <= kdone_d; khit_q <= khit_d;
      spend_q <= spend_d; sdone_q <= sdone_d; shit_q <= shit_d;
      krd_q   <= krd_d;   srd_q   <= srd_d;   step_q <= step_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q <= key_d; sen_q <= sen_d; val_q <= val_d; clr_q <= clr_d;
    kcmp_q <= kcmp_d; kidx_q <= kidx_d;
    e_min_q <= e_min_d; e_max_q <= e_max_d; e_cnt_q <= e_cnt_d;
    mneg_q <= mneg_d; mmag_q <= mmag_d;
    acc_q <= acc_d; mcand_q <= mcand_d; csh_q <= csh_d; dvs_q <= dvs_d;
    rem_q <= rem_d; dvd_q <= dvd_d; qneg_q <= qneg_d;
    kst_q <= kst_d; sst_q <= sst_d;
    out_q <= out_d;
  end

endmodule
